// File: rtl/mbg_pkg.sv
// Shared types and constants of the maze backtracker generator.
`default_nettype none

package mbg_pkg;

	// default geometry and stack size
	localparam int MBG_MAZE_WIDTH  = 31;
	localparam int MBG_MAZE_HEIGHT = 23;
	localparam int MBG_STACK_DEPTH = 192;

	// fixed field widths of the stream payload
	localparam int KIND_W      = 2;
	localparam int RAND_W      = 8;
	localparam int COORD_IN_W  = 5;
	localparam int COORD_OUT_W = 5;
	localparam int S_TDATA_W   = 24;
	localparam int S_TUSER_W   = 2;
	localparam int M_TDATA_W   = 16;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_STEP  = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NOP   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CELL_WALL   = 2'd0,
		CELL_FRESH  = 2'd1,
		CELL_SEEN   = 2'd2,
		CELL_OPENED = 2'd3
	} cell_t;

	// neighbor order: down is row-2, up is row+2
	typedef enum logic [1:0] {
		DIR_DOWN  = 2'd0,
		DIR_RIGHT = 2'd1,
		DIR_UP    = 2'd2,
		DIR_LEFT  = 2'd3
	} dir_t;

	typedef enum logic [3:0] {
		DP_NOP      = 4'd0,
		DP_ACCEPT   = 4'd1,
		DP_INIT     = 4'd2,
		DP_CLR_STEP = 4'd3,
		DP_FIN      = 4'd4,
		DP_NB_RD    = 4'd5,
		DP_PICK     = 4'd6,
		DP_WALL     = 4'd7,
		DP_CELL     = 4'd8,
		DP_POP_RD   = 4'd9,
		DP_POP_LD   = 4'd10,
		DP_READ     = 4'd11
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		dir_t   dir;
	} dp_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic sweep_last;
		logic any_fresh;
		logic stack_empty;
	} dp_status_t;

endpackage

`default_nettype wire

// File: rtl/mbg_dp.sv
// Datapath: grid memory, path stack, walk registers and neighbor selection.
`default_nettype none

module mbg_dp #(
	parameter int MAZE_WIDTH  = mbg_pkg::MBG_MAZE_WIDTH,
	parameter int MAZE_HEIGHT = mbg_pkg::MBG_MAZE_HEIGHT,
	parameter int STACK_DEPTH = mbg_pkg::MBG_STACK_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mbg_pkg::dp_cmd_t                   cmd,
	input  logic [mbg_pkg::RAND_W-1:0]         rand_value,
	input  logic [mbg_pkg::COORD_IN_W-1:0]     read_x,
	input  logic [mbg_pkg::COORD_IN_W-1:0]     read_y,
	output mbg_pkg::dp_status_t                status,
	output logic [mbg_pkg::COORD_OUT_W-1:0]    cur_x,
	output logic [mbg_pkg::COORD_OUT_W-1:0]    cur_y,
	output logic                               carved,
	output logic                               done_res,
	output logic                               cell_open
);
	import mbg_pkg::*;

	localparam int COORD_W   = $clog2(MAZE_WIDTH > MAZE_HEIGHT ? MAZE_WIDTH : MAZE_HEIGHT);
	localparam int EXT_W     = COORD_W + 1;
	localparam int CELLS     = MAZE_WIDTH * MAZE_HEIGHT;
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int FRESH_MAX = (MAZE_WIDTH / 2) * (MAZE_HEIGHT / 2);
	localparam int CNT_W     = $clog2(FRESH_MAX + 1);
	localparam int IDX_W     = $clog2(STACK_DEPTH);
	localparam int SP_W      = $clog2(STACK_DEPTH + 1);
	localparam int ENT_W     = 2 * COORD_W;

	localparam logic [EXT_W-1:0]   W_EXT      = EXT_W'(MAZE_WIDTH);
	localparam logic [EXT_W-1:0]   H_EXT      = EXT_W'(MAZE_HEIGHT);
	localparam logic [COORD_W-1:0] LAST_COL   = COORD_W'(MAZE_WIDTH - 1);
	localparam logic [COORD_W-1:0] LAST_ROW   = COORD_W'(MAZE_HEIGHT - 1);
	localparam logic [SP_W-1:0]    SP_FULL    = SP_W'(STACK_DEPTH);
	localparam logic [ADDR_W-1:0]  START_ADDR = ADDR_W'(MAZE_WIDTH + 1);
	localparam logic [CNT_W-1:0]   CNT_ONE    = CNT_W'(1);

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] col,
			input logic [COORD_W-1:0] row);
		cell_addr = ADDR_W'(32'(row) * MAZE_WIDTH) + ADDR_W'(col);
	endfunction

	// returns {col, row}, one bit wider so stepping off the low edge wraps high
	function automatic logic [2*EXT_W-1:0] move(input logic [COORD_W-1:0] col,
			input logic [COORD_W-1:0] row, input dir_t d, input logic far);
		logic [EXT_W-1:0] c;
		logic [EXT_W-1:0] r;
		logic [EXT_W-1:0] k;
		c = EXT_W'(col);
		r = EXT_W'(row);
		k = far ? EXT_W'(2) : EXT_W'(1);
		unique case (d)
			DIR_DOWN:  r = r - k;
			DIR_RIGHT: c = c + k;
			DIR_UP:    r = r + k;
			DIR_LEFT:  c = c - k;
		endcase
		move = {c, r};
	endfunction

	// byte mod 3: base-4 digits sum, then fold
	function automatic logic [1:0] mod3(input logic [7:0] v);
		logic [3:0] s;
		logic [2:0] t;
		s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
		t = 3'(s[1:0]) + 3'(s[3:2]);
		if (t >= 3'd3) t = t - 3'd3;
		if (t >= 3'd3) t = t - 3'd3;
		mod3 = t[1:0];
	endfunction

	function automatic dir_t pick_dir(input logic [3:0] f, input logic [7:0] rnd);
		logic [2:0] n;
		logic [1:0] idx;
		logic [2:0] seen;
		dir_t       d;
		n    = 3'($countones(f));
		d    = DIR_DOWN;
		seen = '0;
		unique case (n)
			3'd1:    idx = 2'd0;
			3'd2:    idx = {1'b0, rnd[0]};
			3'd3:    idx = mod3(rnd);
			default: idx = rnd[1:0];
		endcase
		for (int i = 0; i < 4; i++) begin
			if (f[i]) begin
				if (seen == {1'b0, idx}) d = dir_t'(2'(i));
				seen = seen + 3'd1;
			end
		end
		pick_dir = d;
	endfunction

	// walk state
	logic [COORD_W-1:0] cur_col_q, cur_row_q;
	logic [SP_W-1:0]    sp_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q, started_q;
	logic [COORD_W-1:0] sweep_col_q, sweep_row_q;
	logic [ADDR_W-1:0]  sweep_addr_q;
	logic [3:0]         fresh_q;
	logic               cap_pend_q, cap_inr_q;
	dir_t               cap_dir_q, pick_dir_q;
	logic               carved_q, is_read_q;
	logic [RAND_W-1:0]  rand_q;
	logic [COORD_IN_W-1:0] rd_x_q, rd_y_q;

	// memories
	cell_t              grid_mem_q [CELLS];
	cell_t              grid_rd_q;
	logic [ENT_W-1:0]   stack_mem_q [STACK_DEPTH];
	logic [ENT_W-1:0]   stack_rd_q;

	dir_t               nb_dir;
	logic [2*EXT_W-1:0] far, mid;
	logic [EXT_W-1:0]   far_c, far_r, mid_c, mid_r;
	logic               far_inr;
	logic [ADDR_W-1:0]  far_addr, mid_addr;
	logic               rd_inr, rd_exit;
	logic [SP_W-1:0]    sp_dec;
	logic               push;
	logic               sweep_fresh;
	logic               g_we, g_re;
	logic [ADDR_W-1:0]  g_addr;
	cell_t              g_wdata;

	assign nb_dir   = (cmd.op == DP_NB_RD) ? cmd.dir : pick_dir_q;
	assign far      = move(cur_col_q, cur_row_q, nb_dir, 1'b1);
	assign mid      = move(cur_col_q, cur_row_q, nb_dir, 1'b0);
	assign far_c    = far[2*EXT_W-1:EXT_W];
	assign far_r    = far[EXT_W-1:0];
	assign mid_c    = mid[2*EXT_W-1:EXT_W];
	assign mid_r    = mid[EXT_W-1:0];
	assign far_inr  = (far_c != '0) && (far_c < W_EXT) && (far_r != '0) && (far_r < H_EXT);
	assign far_addr = cell_addr(far_c[COORD_W-1:0], far_r[COORD_W-1:0]);
	assign mid_addr = cell_addr(mid_c[COORD_W-1:0], mid_r[COORD_W-1:0]);

	assign rd_inr  = (32'(rd_x_q) < MAZE_WIDTH) && (32'(rd_y_q) < MAZE_HEIGHT);
	// exit cell in the right border opens once the walk is finished
	assign rd_exit = done_q && (32'(rd_x_q) == MAZE_WIDTH - 1) && (rd_y_q == COORD_IN_W'(1));

	assign sp_dec      = sp_q - SP_W'(1);
	assign push        = (cmd.op == DP_WALL) && (sp_q < SP_FULL);
	assign sweep_fresh = sweep_col_q[0] & sweep_row_q[0];

	// single grid port
	always_comb begin
		g_we    = 1'b0;
		g_re    = 1'b0;
		g_addr  = '0;
		g_wdata = CELL_WALL;
		unique case (cmd.op)
			DP_CLR_STEP: begin
				g_we    = 1'b1;
				g_addr  = sweep_addr_q;
				g_wdata = sweep_fresh ? CELL_FRESH : CELL_WALL;
			end
			DP_FIN: begin
				g_we    = 1'b1;
				g_addr  = START_ADDR;
				g_wdata = CELL_SEEN;
			end
			DP_NB_RD: begin
				g_re   = far_inr;
				g_addr = far_addr;
			end
			DP_WALL: begin
				g_we    = 1'b1;
				g_addr  = mid_addr;
				g_wdata = CELL_OPENED;
			end
			DP_CELL: begin
				g_we    = 1'b1;
				g_addr  = far_addr;
				g_wdata = CELL_SEEN;
			end
			DP_READ: begin
				g_re   = rd_inr;
				g_addr = cell_addr(COORD_W'(rd_x_q), COORD_W'(rd_y_q));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (g_we) begin
			grid_mem_q[g_addr] <= g_wdata;
		end else if (g_re) begin
			grid_rd_q <= grid_mem_q[g_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			stack_mem_q[sp_q[IDX_W-1:0]] <= {cur_row_q, cur_col_q};
		end else if (cmd.op == DP_POP_RD) begin
			stack_rd_q <= stack_mem_q[sp_dec[IDX_W-1:0]];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.op == DP_ACCEPT) begin
			rand_q <= rand_value;
			rd_x_q <= read_x;
			rd_y_q <= read_y;
		end
		if (cmd.op == DP_PICK) pick_dir_q <= pick_dir(fresh_q, rand_q);
		cap_dir_q <= cmd.dir;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q    <= COORD_W'(1);
			cur_row_q    <= COORD_W'(1);
			sp_q         <= '0;
			cnt_q        <= '0;
			done_q       <= 1'b0;
			started_q    <= 1'b0;
			sweep_col_q  <= '0;
			sweep_row_q  <= '0;
			sweep_addr_q <= '0;
			fresh_q      <= '0;
			cap_pend_q   <= 1'b0;
			cap_inr_q    <= 1'b0;
			carved_q     <= 1'b0;
			is_read_q    <= 1'b0;
		end else begin
			cap_pend_q <= (cmd.op == DP_NB_RD);
			cap_inr_q  <= far_inr;
			unique case (cmd.op)
				DP_ACCEPT: begin
					fresh_q   <= '0;
					carved_q  <= 1'b0;
					is_read_q <= 1'b0;
				end
				DP_INIT: begin
					sweep_col_q  <= '0;
					sweep_row_q  <= '0;
					sweep_addr_q <= '0;
					cnt_q        <= '0;
				end
				DP_CLR_STEP: begin
					if (sweep_fresh) cnt_q <= cnt_q + CNT_ONE;
					if (sweep_col_q == LAST_COL) begin
						sweep_col_q <= '0;
						sweep_row_q <= sweep_row_q + COORD_W'(1);
					end else begin
						sweep_col_q <= sweep_col_q + COORD_W'(1);
					end
					sweep_addr_q <= sweep_addr_q + ADDR_W'(1);
				end
				DP_FIN: begin
					cur_col_q <= COORD_W'(1);
					cur_row_q <= COORD_W'(1);
					cnt_q     <= cnt_q - CNT_ONE;
					done_q    <= (cnt_q == CNT_ONE);
					sp_q      <= '0;
					started_q <= 1'b1;
				end
				DP_WALL: begin
					if (push) sp_q <= sp_q + SP_W'(1);
				end
				DP_CELL: begin
					cur_col_q <= far_c[COORD_W-1:0];
					cur_row_q <= far_r[COORD_W-1:0];
					cnt_q     <= cnt_q - CNT_ONE;
					if (cnt_q == CNT_ONE) done_q <= 1'b1;
					carved_q  <= 1'b1;
				end
				DP_POP_RD: sp_q <= sp_dec;
				DP_POP_LD: begin
					cur_col_q <= stack_rd_q[COORD_W-1:0];
					cur_row_q <= stack_rd_q[ENT_W-1:COORD_W];
				end
				DP_READ: is_read_q <= 1'b1;
				default: ;
			endcase
			// neighbor read data is captured in the cycle after the read
			if (cap_pend_q) fresh_q[cap_dir_q] <= cap_inr_q && (grid_rd_q == CELL_FRESH);
		end
	end

	assign status.count_zero  = (cnt_q == '0);
	assign status.sweep_last  = (sweep_col_q == LAST_COL) && (sweep_row_q == LAST_ROW);
	assign status.any_fresh   = |fresh_q;
	assign status.stack_empty = (sp_q == '0);

	assign cur_x     = COORD_OUT_W'(cur_col_q);
	assign cur_y     = COORD_OUT_W'(cur_row_q);
	assign carved    = carved_q;
	assign done_res  = done_q;
	assign cell_open = is_read_q && (rd_exit || (started_q && rd_inr &&
		(grid_rd_q == CELL_SEEN || grid_rd_q == CELL_OPENED)));

endmodule

`default_nettype wire

// File: rtl/mbg_ctrl.sv
// Controller state machine sequencing start, walk step, read and unused-kind items.
`default_nettype none

module mbg_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [mbg_pkg::KIND_W-1:0]  kind,
	input  mbg_pkg::dp_status_t         status,
	input  logic                        out_free,
	output logic                        resp_valid,
	output mbg_pkg::dp_cmd_t            cmd
);
	import mbg_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_INIT   = 13'b0000000000010,
		ST_CLR    = 13'b0000000000100,
		ST_FIN    = 13'b0000000001000,
		ST_NB     = 13'b0000000010000,
		ST_WAIT   = 13'b0000000100000,
		ST_DECIDE = 13'b0000001000000,
		ST_WALL   = 13'b0000010000000,
		ST_CELL   = 13'b0000100000000,
		ST_POP_RD = 13'b0001000000000,
		ST_POP_LD = 13'b0010000000000,
		ST_READ   = 13'b0100000000000,
		ST_RESP   = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	dir_t   dir_q, dir_d;
	logic   accept;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign resp_valid = (state_q == ST_RESP);

	always_comb begin
		state_d = state_q;
		dir_d   = dir_q;
		cmd.op  = DP_NOP;
		cmd.dir = dir_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.op = DP_ACCEPT;
					dir_d  = DIR_DOWN;
					unique case (kind_t'(kind))
						KIND_START: state_d = ST_INIT;
						KIND_STEP:  state_d = status.count_zero ? ST_RESP : ST_NB;
						KIND_READ:  state_d = ST_READ;
						KIND_NOP:   state_d = ST_RESP;
					endcase
				end
			end
			ST_INIT: begin
				cmd.op  = DP_INIT;
				state_d = ST_CLR;
			end
			ST_CLR: begin
				cmd.op = DP_CLR_STEP;
				if (status.sweep_last) state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.op  = DP_FIN;
				state_d = ST_RESP;
			end
			ST_NB: begin
				cmd.op = DP_NB_RD;
				dir_d  = dir_t'(dir_q + 2'd1);
				if (dir_q == DIR_LEFT) state_d = ST_WAIT;
			end
			ST_WAIT: state_d = ST_DECIDE;
			ST_DECIDE: begin
				cmd.op = DP_PICK;
				priority if (status.any_fresh) state_d = ST_WALL;
				else if (status.stack_empty)   state_d = ST_RESP;
				else                           state_d = ST_POP_RD;
			end
			ST_WALL: begin
				cmd.op  = DP_WALL;
				state_d = ST_CELL;
			end
			ST_CELL: begin
				cmd.op  = DP_CELL;
				state_d = ST_RESP;
			end
			ST_POP_RD: begin
				cmd.op  = DP_POP_RD;
				state_d = ST_POP_LD;
			end
			ST_POP_LD: begin
				cmd.op  = DP_POP_LD;
				state_d = ST_RESP;
			end
			ST_READ: begin
				cmd.op  = DP_READ;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dir_q   <= DIR_DOWN;
		end else begin
			state_q <= state_d;
			dir_q   <= dir_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/maze_backtracker_generator.sv
// Top level of the maze backtracker generator: controller, datapath, output register.
`default_nettype none

// Depth-first maze carver on a MAZE_WIDTH x MAZE_HEIGHT grid (default 31 x 23).
// Each input transfer is one item and yields exactly one result transfer.
// Item kinds (s_tuser): start clears the grid to walls, marks odd cells
// unvisited and puts the walk at (1,1); step carves toward a random unvisited
// neighbor two cells away, or backtracks one stack entry; read reports whether
// a cell is a passage (the exit at the right border, row 1, reads open once the
// walk is done). Before the first start every cell reads as wall and steps do
// nothing. The block handles one item at a time; all cell traffic goes through
// a single-port grid memory, so each item is carried out in these steps:
//   start: one grid write per cell in a sweep of the whole grid, then the
//          start cell is marked visited
//   step : four neighbor reads, a wait, decide, then two writes or a stack pop;
//          a dead end with an empty stack ends at decide; once the walk is done
//          the step goes straight to its result
//   read : one grid read; unused kind: straight to its result
// A new item is taken while an earlier result still waits in the output
// register; the block then holds its result until the register frees up.
// The path stack holds STACK_DEPTH entries; a push onto a full stack is dropped.
module maze_backtracker_generator #(
	parameter int MAZE_WIDTH  = mbg_pkg::MBG_MAZE_WIDTH,   // 5..32
	parameter int MAZE_HEIGHT = mbg_pkg::MBG_MAZE_HEIGHT,  // 5..32
	parameter int STACK_DEPTH = mbg_pkg::MBG_STACK_DEPTH   // 8..1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// rand_value[7:0], read_x[12:8], read_y[17:13], zero [23:18]
	input  logic [mbg_pkg::S_TDATA_W-1:0]   s_tdata,
	// kind[1:0]
	input  logic [mbg_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// cur_x[4:0], cur_y[9:5], carved[10], done_res[11], cell_open[12], zero [15:13]
	output logic [mbg_pkg::M_TDATA_W-1:0]   m_tdata
);
	import mbg_pkg::*;

	dp_cmd_t                cmd;
	dp_status_t             status;
	logic                   resp_valid;
	logic                   out_free;
	logic                   out_load;
	logic [COORD_OUT_W-1:0] cur_x, cur_y;
	logic                   carved, done_res, cell_open;
	logic                   m_tvalid_q;
	logic [M_TDATA_W-1:0]   m_tdata_q;

	// output register frees when empty or drained this cycle
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = resp_valid && out_free;

	mbg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.kind       (s_tuser[KIND_W-1:0]),
		.status     (status),
		.out_free   (out_free),
		.resp_valid (resp_valid),
		.cmd        (cmd)
	);

	mbg_dp #(
		.MAZE_WIDTH  (MAZE_WIDTH),
		.MAZE_HEIGHT (MAZE_HEIGHT),
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rand_value (s_tdata[RAND_W-1:0]),
		.read_x     (s_tdata[RAND_W+COORD_IN_W-1:RAND_W]),
		.read_y     (s_tdata[RAND_W+2*COORD_IN_W-1:RAND_W+COORD_IN_W]),
		.status     (status),
		.cur_x      (cur_x),
		.cur_y      (cur_y),
		.carved     (carved),
		.done_res   (done_res),
		.cell_open  (cell_open)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= M_TDATA_W'({cell_open, done_res, carved, cur_y, cur_x});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

// File: rtl/mbg_checker.sv
// Port-level checker for the maze backtracker generator, bound to the top level.
`default_nettype none

module mbg_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [mbg_pkg::S_TDATA_W-1:0]   s_tdata,
	input logic [mbg_pkg::S_TUSER_W-1:0]   s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [mbg_pkg::M_TDATA_W-1:0]   m_tdata
);
	import mbg_pkg::*;

	logic       in_xfer, out_xfer;
	logic [1:0] pend_q;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	// items taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_xfer) - 2'(out_xfer);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped while stalled");

	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q <= 2'd2) && (!m_tvalid || pend_q != 2'd0))
		else $error("result count does not match item count");

	a_odd_cell: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[0] && m_tdata[5])
		else $error("walk left the odd-coordinate cells");

	a_carve_read: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[10] && m_tdata[12]))
		else $error("carved and cell_open set together");

endmodule

bind maze_backtracker_generator mbg_checker u_mbg_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the maze backtracker generator stream block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mbg_pkg::*;

	localparam int GRID_W       = MBG_MAZE_WIDTH;
	localparam int GRID_H       = MBG_MAZE_HEIGHT;
	localparam int TRAIL_DEPTH  = MBG_STACK_DEPTH;
	localparam int ITEM_TOTAL   = 1950;
	localparam int ITEMS_PER_WALK = 420;     // enough steps to finish a 15 x 11 cell walk
	localparam int HOLD_AFTER   = 500;       // results taken before the long receiver hold
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PROBE_ROWS   = 22;

	// m_tdata layout, lowest bit first: cur_x, cur_y, carved, done_res, cell_open, pad
	typedef struct packed {
		logic [2:0] pad;
		logic       cell_open;
		logic       done_res;
		logic       carved;
		logic [4:0] cur_y;
		logic [4:0] cur_x;
	} maze_result_t;

	typedef struct packed {
		logic [5:0] y;
		logic [5:0] x;
	} walk_pos_t;

	typedef struct {
		bit           typed;
		maze_result_t want;
	} fixed_t;

	// directed probe: typed = 1 means the expected fields below are used as is
	typedef struct packed {
		kind_t      kind;
		logic [7:0] rnd;
		logic [4:0] rx;
		logic [4:0] ry;
		logic       typed;
		logic [4:0] ex;
		logic [4:0] ey;
		logic       ec;
		logic       ed;
		logic       eo;
	} probe_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;

	maze_backtracker_generator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ---------------------------------------------------------------
	// Predictor state: own copy of the grid, walk position and path
	// ---------------------------------------------------------------
	cell_t     grid_mem [GRID_H][GRID_W];
	walk_pos_t trail [$];
	int        walk_x     = 1;
	int        walk_y     = 1;
	int        fresh_left = 0;
	bit        maze_done  = 1'b0;

	initial foreach (grid_mem[r, c]) grid_mem[r][c] = CELL_WALL;

	maze_result_t expected_results [$];
	fixed_t       fixed_q [$];
	int           errors = 0;
	bit           feed_done = 1'b0;
	bit           feed_calm = 1'b0;
	bit           sink_calm = 1'b0;

	// coverage tallies for the closing summary
	int n_items = 0, n_starts = 0, n_steps = 0, n_carves = 0;
	int n_reads = 0, n_open = 0, n_mazes = 0, n_results = 0;

	// Applies one item to the predictor state and returns the result it causes.
	function automatic maze_result_t carve_predict(kind_t k, logic [7:0] rnd,
			logic [4:0] rx, logic [4:0] ry);
		maze_result_t res;
		int n, pick, nx, ny;
		int cand_x [4];
		int cand_y [4];
		walk_pos_t popped;
		res = '0;
		case (k)
			KIND_START: begin
				foreach (grid_mem[r, c]) grid_mem[r][c] = CELL_WALL;
				fresh_left = 0;
				for (int r = 1; r < GRID_H; r += 2)
					for (int c = 1; c < GRID_W; c += 2) begin
						grid_mem[r][c] = CELL_FRESH;
						fresh_left++;
					end
				walk_x = 1;
				walk_y = 1;
				grid_mem[1][1] = CELL_SEEN;
				fresh_left--;
				trail.delete();
				maze_done = (fresh_left == 0);
			end
			KIND_STEP: begin
				// nothing left to visit: the step is a no-op
				if (fresh_left != 0) begin
					n = 0;
					for (int d = 0; d < 4; d++) begin
						nx = walk_x;
						ny = walk_y;
						case (dir_t'(d))
							DIR_DOWN:  ny = walk_y - 2;
							DIR_RIGHT: nx = walk_x + 2;
							DIR_UP:    ny = walk_y + 2;
							default:   nx = walk_x - 2;
						endcase
						if (nx > 0 && nx < GRID_W && ny > 0 && ny < GRID_H &&
								grid_mem[ny][nx] == CELL_FRESH) begin
							cand_x[n] = nx;
							cand_y[n] = ny;
							n++;
						end
					end
					if (n == 0) begin
						// dead end: backtrack, stays put on an empty path
						if (trail.size() > 0) begin
							popped = trail.pop_back();
							walk_x = popped.x;
							walk_y = popped.y;
						end
					end else begin
						pick = int'(rnd) % n;
						if (trail.size() < TRAIL_DEPTH)
							trail.push_back(walk_pos_t'{y: 6'(walk_y), x: 6'(walk_x)});
						grid_mem[(walk_y + cand_y[pick]) / 2][(walk_x + cand_x[pick]) / 2] =
							CELL_OPENED;
						walk_x = cand_x[pick];
						walk_y = cand_y[pick];
						grid_mem[walk_y][walk_x] = CELL_SEEN;
						fresh_left--;
						if (fresh_left == 0)
							maze_done = 1'b1;
						res.carved = 1'b1;
					end
				end
			end
			KIND_READ: begin
				// off-grid coordinates read as wall; exit opens once the walk ends
				if (int'(rx) < GRID_W && int'(ry) < GRID_H) begin
					if (maze_done && int'(rx) == GRID_W - 1 && ry == 5'd1)
						res.cell_open = 1'b1;
					else
						res.cell_open = (grid_mem[ry][rx] == CELL_SEEN ||
							grid_mem[ry][rx] == CELL_OPENED);
				end
			end
			default: ;
		endcase
		res.cur_x = 5'(walk_x);
		res.cur_y = 5'(walk_y);
		res.done_res = maze_done;
		return res;
	endfunction

	function automatic void check_field(string what, int want, int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			errors++;
		end
	endfunction

	// Wait before the next transfer; calm stretches have no gaps at all.
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	task automatic offer(input kind_t k, input logic [7:0] rnd, input logic [4:0] rx,
			input logic [4:0] ry, input bit typed, input maze_result_t want);
		int gap;
		gap = draw_wait(feed_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		fixed_q.push_back(fixed_t'{typed, want});
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= {6'd0, ry, rx, rnd};
		do @(posedge clk); while (!(s_tvalid && s_tready));
	endtask

	task automatic offer_random(input kind_t k, input logic [4:0] rx, input logic [4:0] ry);
		offer(k, 8'($urandom_range(0, 255)), rx, ry, 1'b0, '0);
	endtask

	// Directed probes: behavior before any start, off-grid reads, the unused
	// kind, exit before completion, and a restart in the middle of a walk.
	probe_row_t probes [PROBE_ROWS] = '{
		'{KIND_READ,  8'h00, 5'd0,  5'd0,  1'b1, 5'd1, 5'd1, 1'b0, 1'b0, 1'b0},
		'{KIND_STEP,  8'hff, 5'd0,  5'd0,  1'b1, 5'd1, 5'd1, 1'b0, 1'b0, 1'b0},
		'{KIND_NOP,   8'hff, 5'd31, 5'd31, 1'b1, 5'd1, 5'd1, 1'b0, 1'b0, 1'b0},
		'{KIND_READ,  8'h00, 5'd31, 5'd31, 1'b1, 5'd1, 5'd1, 1'b0, 1'b0, 1'b0},
		'{KIND_START, 8'h00, 5'd0,  5'd0,  1'b1, 5'd1, 5'd1, 1'b0, 1'b0, 1'b0},
		'{KIND_READ,  8'h00, 5'd1,  5'd1,  1'b1, 5'd1, 5'd1, 1'b0, 1'b0, 1'b1},
		'{KIND_READ,  8'h00, 5'd30, 5'd1,  1'b1, 5'd1, 5'd1, 1'b0, 1'b0, 1'b0},
		'{KIND_READ,  8'hff, 5'd31, 5'd1,  1'b1, 5'd1, 5'd1, 1'b0, 1'b0, 1'b0},
		'{KIND_READ,  8'h00, 5'd1,  5'd23, 1'b1, 5'd1, 5'd1, 1'b0, 1'b0, 1'b0},
		'{KIND_READ,  8'h00, 5'd30, 5'd22, 1'b1, 5'd1, 5'd1, 1'b0, 1'b0, 1'b0},
		'{KIND_STEP,  8'h00, 5'd0,  5'd0,  1'b0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0},
		'{KIND_STEP,  8'hff, 5'd0,  5'd0,  1'b0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0},
		'{KIND_STEP,  8'h80, 5'd0,  5'd0,  1'b0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0},
		'{KIND_STEP,  8'h55, 5'd0,  5'd0,  1'b0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0},
		'{KIND_READ,  8'h00, 5'd2,  5'd1,  1'b0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0},
		'{KIND_NOP,   8'haa, 5'd21, 5'd10, 1'b0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0},
		'{KIND_START, 8'h00, 5'd0,  5'd0,  1'b1, 5'd1, 5'd1, 1'b0, 1'b0, 1'b0},
		'{KIND_READ,  8'h00, 5'd3,  5'd1,  1'b1, 5'd1, 5'd1, 1'b0, 1'b0, 1'b0},
		'{KIND_STEP,  8'h01, 5'd0,  5'd0,  1'b0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0},
		'{KIND_STEP,  8'h02, 5'd0,  5'd0,  1'b0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0},
		'{KIND_STEP,  8'h03, 5'd0,  5'd0,  1'b0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0},
		'{KIND_READ,  8'h00, 5'd1,  5'd3,  1'b0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0}
	};

	// ---------------------------------------------------------------
	// Sender: directed probes, then walks of random steps with reads, unused kinds and rare restarts mixed in
	// ---------------------------------------------------------------
	initial begin : feeder
		maze_result_t want;
		int sent, roll;
		logic [4:0] rx, ry;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = KIND_NOP;
		wait (arst_n === 1'b1);
		@(posedge clk);
		foreach (probes[i]) begin
			want = '0;
			want.cur_x     = probes[i].ex;
			want.cur_y     = probes[i].ey;
			want.carved    = probes[i].ec;
			want.done_res  = probes[i].ed;
			want.cell_open = probes[i].eo;
			offer(probes[i].kind, probes[i].rnd, probes[i].rx, probes[i].ry,
				probes[i].typed, want);
		end
		sent = PROBE_ROWS;
		while (sent < ITEM_TOTAL) begin
			offer_random(KIND_START, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
			sent++;
			for (int i = 0; i < ITEMS_PER_WALK && sent < ITEM_TOTAL; i++) begin
				roll = $urandom_range(0, 99);
				rx = 5'($urandom_range(0, 31));
				ry = 5'($urandom_range(0, 31));
				if (roll < 84) begin
					offer_random(KIND_STEP, rx, ry);
				end else if (roll < 97) begin
					// mostly in-grid reads, some aimed at the exit cell
					if ($urandom_range(0, 9) == 0) begin
						rx = 5'(GRID_W - 1);
						ry = 5'd1;
					end else if ($urandom_range(0, 7) != 0) begin
						rx = 5'($urandom_range(0, GRID_W - 1));
						ry = 5'($urandom_range(0, GRID_H - 1));
					end
					offer_random(KIND_READ, rx, ry);
				end else if (roll < 99 || $urandom_range(0, 9) != 0) begin
					offer_random(KIND_NOP, rx, ry);
				end else begin
					// rare restart cuts the walk short
					offer_random(KIND_START, rx, ry);
				end
				sent++;
			end
		end
		s_tvalid <= 1'b0;
		feed_done = 1'b1;
	end

	// ---------------------------------------------------------------
	// Receiver: random stalls, plus one long hold so the block backs up
	// ---------------------------------------------------------------
	initial begin : sink
		int stall, taken;
		bit held;
		m_tready = 1'b0;
		taken = 0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && taken == HOLD_AFTER) begin
				held = 1'b1;
				stall = HOLD_CYCLES;
			end else begin
				stall = draw_wait(sink_calm);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			taken++;
		end
	end

	// ---------------------------------------------------------------
	// Scoreboard: outputs checked before the same-edge input is predicted
	// ---------------------------------------------------------------
	always @(posedge clk) begin : scoreboard
		maze_result_t got, want, model;
		fixed_t fx;
		bit was_done;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = maze_result_t'(m_tdata);
				n_results++;
				if (expected_results.size() == 0) begin
					$display("%0t ns: result transfer with nothing outstanding, got %h",
						$time, m_tdata);
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("cur_x",     want.cur_x,     got.cur_x);
					check_field("cur_y",     want.cur_y,     got.cur_y);
					check_field("carved",    want.carved,    got.carved);
					check_field("done_res",  want.done_res,  got.done_res);
					check_field("cell_open", want.cell_open, got.cell_open);
				end
			end
			if (s_tvalid && s_tready) begin
				was_done = maze_done;
				model = carve_predict(kind_t'(s_tuser), s_tdata[7:0], s_tdata[12:8],
					s_tdata[17:13]);
				fx = fixed_q.pop_front();
				expected_results.push_back(fx.typed ? fx.want : model);
				n_items++;
				case (kind_t'(s_tuser))
					KIND_START: n_starts++;
					KIND_STEP: begin
						n_steps++;
						if (model.carved)
							n_carves++;
					end
					KIND_READ: begin
						n_reads++;
						if (model.cell_open)
							n_open++;
					end
					default: ;
				endcase
				if (!was_done && maze_done)
					n_mazes++;
			end
		end
	end

	// Watchdog: too long without any transfer on either side
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
			$time, QUIET_LIMIT, expected_results.size());
		$display("Some tests failed");
		$finish;
	end

	initial begin : closer
		wait (feed_done);
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		// catch stray results after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d transfers in: %0d starts, %0d steps (%0d carving), %0d reads",
			n_items, n_starts, n_steps, n_carves, n_reads);
		$display("  %0d reads found passages, %0d mazes carved to completion, %0d results",
			n_open, n_mazes, n_results);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
